// File: sv/mces_pkg.sv
`timescale 1ns / 1ps

package mces_pkg;

   localparam int COUNT_W     = 16;
   localparam int BUTTON_W    = 3;
   localparam int STATUS_W    = 7;
   localparam int POS_W       = 21;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int REQ_DATA_W  = 40;
   localparam int RSP_DATA_W  = 88;

   localparam int DEFAULT_X_GAIN = 2;
   localparam int DEFAULT_Y_GAIN = 2;

   localparam logic [CSR_INDEX_W-1:0] REG_BOUND_LEFT    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_BOUND_BOTTOM  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_BOUND_RIGHT   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_BOUND_TOP     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_ORIGIN_X      = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_ORIGIN_Y      = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_RELATIVE_MODE = 3'd6;

   localparam logic signed [COUNT_W-1:0] RESET_BOUND_LOW  = -16'sd4095;
   localparam logic signed [COUNT_W-1:0] RESET_BOUND_HIGH = 16'sd4096;
   localparam logic signed [COUNT_W-1:0] RESET_ORIGIN     = 16'sd0;
   localparam logic signed [POS_W-1:0]   RESET_LAST_POS   = -21'sd1;

   typedef struct packed {
      logic signed [COUNT_W-1:0] bound_left;
      logic signed [COUNT_W-1:0] bound_bottom;
      logic signed [COUNT_W-1:0] bound_right;
      logic signed [COUNT_W-1:0] bound_top;
      logic signed [COUNT_W-1:0] origin_x;
      logic signed [COUNT_W-1:0] origin_y;
      logic                      relative_mode;
      logic                      origin_zeroed;
   } cfg_type;

   typedef struct packed {
      logic [BUTTON_W-1:0]       button_lines;
      logic signed [COUNT_W-1:0] count_y;
      logic signed [COUNT_W-1:0] count_x;
   } req_type;

   typedef struct packed {
      logic signed [COUNT_W-1:0] counter_write_y;
      logic signed [COUNT_W-1:0] counter_write_x;
      logic signed [POS_W-1:0]   pos_y;
      logic signed [POS_W-1:0]   pos_x;
      logic [STATUS_W-1:0]       status;
      logic                      event_res;
   } rsp_type;

endpackage

// File: sv/mces_csr.sv
`timescale 1ns / 1ps

module mces_csr
   import mces_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   input  logic                   zero_set,
   output cfg_type                cfg
);

   logic signed [COUNT_W-1:0] bound_left_ff, bound_left_in;
   logic signed [COUNT_W-1:0] bound_bottom_ff, bound_bottom_in;
   logic signed [COUNT_W-1:0] bound_right_ff, bound_right_in;
   logic signed [COUNT_W-1:0] bound_top_ff, bound_top_in;
   logic signed [COUNT_W-1:0] origin_x_ff, origin_x_in;
   logic signed [COUNT_W-1:0] origin_y_ff, origin_y_in;
   logic                      relative_mode_ff, relative_mode_in;
   logic                      origin_zeroed_ff, origin_zeroed_in;
   logic                      write;
   logic                      origin_write;

   assign write = csr_valid && csr_ready;

   always_comb begin
      bound_left_in    = bound_left_ff;
      bound_bottom_in  = bound_bottom_ff;
      bound_right_in   = bound_right_ff;
      bound_top_in     = bound_top_ff;
      origin_x_in      = origin_x_ff;
      origin_y_in      = origin_y_ff;
      relative_mode_in = relative_mode_ff;
      origin_write     = 1'b0;
      if (write) begin
         case (csr_index)
            REG_BOUND_LEFT: begin
               bound_left_in = csr_data;
            end
            REG_BOUND_BOTTOM: begin
               bound_bottom_in = csr_data;
            end
            REG_BOUND_RIGHT: begin
               bound_right_in = csr_data;
            end
            REG_BOUND_TOP: begin
               bound_top_in = csr_data;
            end
            REG_ORIGIN_X: begin
               origin_x_in  = csr_data;
               origin_write = 1'b1;
            end
            REG_ORIGIN_Y: begin
               origin_y_in  = csr_data;
               origin_write = 1'b1;
            end
            REG_RELATIVE_MODE: begin
               relative_mode_in = csr_data[0];
            end
            default: begin
            end
         endcase
      end
      if (zero_set) begin
         origin_zeroed_in = 1'b1;
      end else if (origin_write) begin
         origin_zeroed_in = 1'b0;
      end else begin
         origin_zeroed_in = origin_zeroed_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bound_left_ff    <= RESET_BOUND_LOW;
         bound_bottom_ff  <= RESET_BOUND_LOW;
         bound_right_ff   <= RESET_BOUND_HIGH;
         bound_top_ff     <= RESET_BOUND_HIGH;
         origin_x_ff      <= RESET_ORIGIN;
         origin_y_ff      <= RESET_ORIGIN;
         relative_mode_ff <= 1'b0;
         origin_zeroed_ff <= 1'b0;
      end else begin
         bound_left_ff    <= bound_left_in;
         bound_bottom_ff  <= bound_bottom_in;
         bound_right_ff   <= bound_right_in;
         bound_top_ff     <= bound_top_in;
         origin_x_ff      <= origin_x_in;
         origin_y_ff      <= origin_y_in;
         relative_mode_ff <= relative_mode_in;
         origin_zeroed_ff <= origin_zeroed_in;
      end
   end

   // While zeroed, both origins read as zero.
   always_comb begin
      cfg.bound_left    = bound_left_ff;
      cfg.bound_bottom  = bound_bottom_ff;
      cfg.bound_right   = bound_right_ff;
      cfg.bound_top     = bound_top_ff;
      cfg.origin_x      = origin_zeroed_ff ? RESET_ORIGIN : origin_x_ff;
      cfg.origin_y      = origin_zeroed_ff ? RESET_ORIGIN : origin_y_ff;
      cfg.relative_mode = relative_mode_ff;
      cfg.origin_zeroed = origin_zeroed_ff;
   end

endmodule

// File: sv/mces_axis.sv
`timescale 1ns / 1ps

module mces_axis
   import mces_pkg::*;
#(
   parameter int GAIN = DEFAULT_X_GAIN
)
(
   input  logic signed [COUNT_W-1:0] count,
   input  logic signed [COUNT_W-1:0] origin,
   input  logic signed [COUNT_W-1:0] bound_low,
   input  logic signed [COUNT_W-1:0] bound_high,
   output logic signed [POS_W-1:0]   pos,
   output logic signed [COUNT_W-1:0] write_back
);

   logic signed [COUNT_W:0]   diff;
   logic signed [COUNT_W:0]   low_ext;
   logic signed [COUNT_W:0]   high_ext;
   logic signed [COUNT_W:0]   low_clamped;
   logic signed [COUNT_W:0]   clamped;
   logic signed [COUNT_W-1:0] rel;

   assign low_ext  = (COUNT_W+1)'(bound_low);
   assign high_ext = (COUNT_W+1)'(bound_high);
   assign diff     = (COUNT_W+1)'(count) - (COUNT_W+1)'(origin);

   // The lower bound goes first, so crossed bounds settle on the upper one.
   assign low_clamped = (diff < low_ext) ? low_ext : diff;
   assign clamped     = (low_clamped > high_ext) ? high_ext : low_clamped;
   assign rel         = clamped[COUNT_W-1:0];

   assign write_back = rel + origin;
   assign pos        = POS_W'(rel) * $signed(POS_W'(GAIN));

endmodule

// File: sv/mces_track.sv
`timescale 1ns / 1ps

module mces_track
   import mces_pkg::*;
#(
   parameter int X_GAIN = DEFAULT_X_GAIN,
   parameter int Y_GAIN = DEFAULT_Y_GAIN
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    step,
   input  req_type req,
   input  cfg_type cfg,
   output rsp_type rsp,
   output logic    zero_set,
   output logic    buttons_known
);

   logic signed [POS_W-1:0]   last_pos_x_ff, last_pos_x_in;
   logic signed [POS_W-1:0]   last_pos_y_ff, last_pos_y_in;
   logic [BUTTON_W-1:0]       last_buttons_ff, last_buttons_in;
   logic                      buttons_known_ff, buttons_known_in;
   logic signed [POS_W-1:0]   pos_x;
   logic signed [POS_W-1:0]   pos_y;
   logic signed [COUNT_W-1:0] write_x;
   logic signed [COUNT_W-1:0] write_y;
   logic                      moved;
   logic                      ev;
   logic [BUTTON_W-1:0]       changed;

   mces_axis #(.GAIN(X_GAIN)) u_axis_x (
      .count      (req.count_x),
      .origin     (cfg.origin_x),
      .bound_low  (cfg.bound_left),
      .bound_high (cfg.bound_right),
      .pos        (pos_x),
      .write_back (write_x)
   );

   mces_axis #(.GAIN(Y_GAIN)) u_axis_y (
      .count      (req.count_y),
      .origin     (cfg.origin_y),
      .bound_low  (cfg.bound_bottom),
      .bound_high (cfg.bound_top),
      .pos        (pos_y),
      .write_back (write_y)
   );

   always_comb begin
      moved   = (pos_x != last_pos_x_ff) || (pos_y != last_pos_y_ff);
      ev      = moved || !buttons_known_ff || (req.button_lines != last_buttons_ff);
      changed = buttons_known_ff ? (req.button_lines ^ last_buttons_ff) : '1;

      rsp.event_res = ev;
      rsp.status    = ev ? {moved, changed, req.button_lines} : '0;
      rsp.pos_x     = pos_x;
      rsp.pos_y     = pos_y;
      if (ev && cfg.relative_mode) begin
         rsp.counter_write_x = '0;
         rsp.counter_write_y = '0;
      end else begin
         rsp.counter_write_x = write_x;
         rsp.counter_write_y = write_y;
      end

      zero_set = step && ev && cfg.relative_mode;

      if (step && ev) begin
         last_pos_x_in    = pos_x;
         last_pos_y_in    = pos_y;
         last_buttons_in  = req.button_lines;
         buttons_known_in = 1'b1;
      end else begin
         last_pos_x_in    = last_pos_x_ff;
         last_pos_y_in    = last_pos_y_ff;
         last_buttons_in  = last_buttons_ff;
         buttons_known_in = buttons_known_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_pos_x_ff    <= RESET_LAST_POS;
         last_pos_y_ff    <= RESET_LAST_POS;
         last_buttons_ff  <= '0;
         buttons_known_ff <= 1'b0;
      end else begin
         last_pos_x_ff    <= last_pos_x_in;
         last_pos_y_ff    <= last_pos_y_in;
         last_buttons_ff  <= last_buttons_in;
         buttons_known_ff <= buttons_known_in;
      end
   end

   assign buttons_known = buttons_known_ff;

endmodule

// File: sv/mouse_counter_event_sampler.sv
`timescale 1ns / 1ps

// Samples a quadrature mouse once per request beat and returns exactly one response beat for
// each. A beat is taken every cycle at full rate unless a stalled result holds the input
// register. Each beat passes from the input register through a single combinational clamp,
// gain multiply and change compare into the result register. The remembered position and
// buttons update as each beat passes into the result register, so the next beat is compared
// against them with no bubble. Configuration writes are taken every cycle and should be made
// only while no beat is in flight.
module mouse_counter_event_sampler
   import mces_pkg::*;
#(
   parameter int X_GAIN = DEFAULT_X_GAIN,
   parameter int Y_GAIN = DEFAULT_Y_GAIN
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // count_x[15:0], count_y[31:16], button_lines[34:32], zero fill above
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // event_res[0], status[7:1], pos_x[28:8], pos_y[49:29], counter_write_x[65:50],
   // counter_write_y[81:66], zero fill above
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;
   rsp_type result;
   cfg_type cfg;
   logic    advance;
   logic    step;
   logic    zero_set;
   logic    buttons_known;
   logic    req_take;

   assign csr_ready = 1'b1;

   mces_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .zero_set  (zero_set),
      .cfg       (cfg)
   );

   mces_track #(.X_GAIN(X_GAIN), .Y_GAIN(Y_GAIN)) u_track (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .req           (in_data_ff),
      .cfg           (cfg),
      .rsp           (result),
      .zero_set      (zero_set),
      .buttons_known (buttons_known)
   );

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign step       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      if (step) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_tdata[$bits(req_type)-1:0];
      end
      if (step) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - $bits(rsp_type)){1'b0}}, rsp_data_ff};

   a_hold_when_full: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && rsp_valid_ff && !rsp_tready |-> !req_tready)
      else $error("input register full behind a stalled result but still ready");

   a_first_event: assert property (@(posedge clock) disable iff (reset)
      step && !buttons_known |=> rsp_valid_ff && rsp_data_ff.event_res)
      else $error("first sample after reset did not report an event");

   a_relative_zero: assert property (@(posedge clock) disable iff (reset)
      step && zero_set |=> cfg.origin_zeroed)
      else $error("relative event did not zero the origin");

   a_quiet_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.event_res |-> rsp_data_ff.status == '0)
      else $error("status nonzero on a beat without an event");

endmodule
